[sv/keypad_integer_calculator_assert.svh]
// Assertion macros used by the calculator top-level RTL.
// Each macro expects clk and rst_n in scope.
`ifndef KEYPAD_INTEGER_CALCULATOR_ASSERT_SVH
`define KEYPAD_INTEGER_CALCULATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KIC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KIC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/kic_pkg.sv]
`default_nettype none

package kic_pkg;

  localparam int unsigned VALUE_W = 16;

  typedef logic [7:0] key_t;
  typedef logic [1:0] op_t;
  typedef logic [2:0] cmd_kind_t;
  typedef logic [3:0] digit_t;

  localparam key_t KEY_NONE = 8'h00;
  localparam key_t KEY_0    = 8'h30;
  localparam key_t KEY_9    = 8'h39;
  localparam key_t KEY_ADD  = 8'h2B;
  localparam key_t KEY_SUB  = 8'h2D;
  localparam key_t KEY_MUL  = 8'h2A;
  localparam key_t KEY_DIV  = 8'h2F;
  localparam key_t KEY_EQ   = 8'h3D;
  localparam key_t KEY_DOT  = 8'h2E;

  localparam op_t OP_ADD = 2'd0;
  localparam op_t OP_SUB = 2'd1;
  localparam op_t OP_MUL = 2'd2;
  localparam op_t OP_DIV = 2'd3;

  localparam cmd_kind_t CMD_ADD   = 3'd0;
  localparam cmd_kind_t CMD_SUB   = 3'd1;
  localparam cmd_kind_t CMD_MUL   = 3'd2;
  localparam cmd_kind_t CMD_DIV   = 3'd3;
  localparam cmd_kind_t CMD_PASS  = 3'd4;
  localparam cmd_kind_t CMD_MAC10 = 3'd5;

  typedef struct packed {
    logic      start;
    cmd_kind_t kind;
    digit_t    digit;
  } eng_cmd_t;

  typedef struct packed {
    logic done;
    logic error;
  } eng_sts_t;

  function automatic cmd_kind_t op_to_cmd(input op_t op);
    cmd_kind_t k;
    unique case (op)
      OP_ADD:  k = CMD_ADD;
      OP_SUB:  k = CMD_SUB;
      OP_MUL:  k = CMD_MUL;
      OP_DIV:  k = CMD_DIV;
      default: k = CMD_ADD;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

[sv/kic_engine.sv]
`default_nettype none

module kic_engine #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire kic_pkg::eng_cmd_t       cmd,
  input  wire logic [DATA_WIDTH-1:0]   opa,
  input  wire logic [DATA_WIDTH-1:0]   opb,
  output kic_pkg::eng_sts_t            sts,
  output logic [DATA_WIDTH-1:0]        result
);

  localparam int unsigned W     = DATA_WIDTH;
  localparam int unsigned CNT_W = $clog2(DATA_WIDTH);

  localparam logic [1:0] E_IDLE = 2'd0;
  localparam logic [1:0] E_RUN  = 2'd1;
  localparam logic [1:0] E_FIX  = 2'd2;

  logic [1:0]               st_r, st_nxt;
  kic_pkg::cmd_kind_t       kind_r, kind_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [W-1:0]             x_r, x_nxt;
  logic [W-1:0]             y_r, y_nxt;
  logic [W-1:0]             acc_r, acc_nxt;
  logic [W-1:0]             rem_r, rem_nxt;
  logic [1:0]               carry_r, carry_nxt;
  logic [2:0]               hist_r, hist_nxt;
  kic_pkg::digit_t          dig_r, dig_nxt;
  logic                     neg_r, neg_nxt;
  logic                     done_r, done_nxt;
  logic                     err_r, err_nxt;

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    return v[W-1] ? (W'(0) - v) : v;
  endfunction

  always_comb begin
    logic [2:0] s3;
    logic [1:0] s2;
    logic [W:0] rem_sh;
    logic [W:0] diff;
    st_nxt    = st_r;
    kind_nxt  = kind_r;
    cnt_nxt   = cnt_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    carry_nxt = carry_r;
    hist_nxt  = hist_r;
    dig_nxt   = dig_r;
    neg_nxt   = neg_r;
    done_nxt  = 1'b0;
    err_nxt   = err_r;
    s3        = 3'(hist_r[0]) + 3'(hist_r[2]) + 3'(dig_r[0]) + 3'(carry_r);
    s2        = 2'(x_r[0]) + 2'(y_r[0]) + 2'(carry_r[0]);
    rem_sh    = {rem_r, x_r[W-1]};
    diff      = rem_sh - {1'b0, y_r};
    unique case (st_r)
      E_IDLE: begin
        if (cmd.start) begin
          kind_nxt  = cmd.kind;
          cnt_nxt   = CNT_W'(W - 1);
          x_nxt     = opa;
          y_nxt     = opb;
          acc_nxt   = '0;
          rem_nxt   = '0;
          carry_nxt = 2'd0;
          hist_nxt  = 3'd0;
          dig_nxt   = cmd.digit;
          neg_nxt   = 1'b0;
          err_nxt   = 1'b0;
          st_nxt    = E_RUN;
          unique case (cmd.kind)
            kic_pkg::CMD_SUB: begin
              y_nxt     = ~opb;
              carry_nxt = 2'd1;
            end
            kic_pkg::CMD_DIV: begin
              x_nxt   = mag(opa);
              y_nxt   = mag(opb);
              neg_nxt = opa[W-1] ^ opb[W-1];
              if (opb == '0) begin
                x_nxt   = '0;
                err_nxt = 1'b1;
                st_nxt  = E_FIX;
              end
            end
            kic_pkg::CMD_PASS: begin
              st_nxt = E_FIX;
            end
            default: begin
            end
          endcase
        end
      end
      E_RUN: begin
        unique case (kind_r)
          kic_pkg::CMD_MAC10: begin
            x_nxt     = {s3[0], x_r[W-1:1]};
            hist_nxt  = {hist_r[1:0], x_r[0]};
            dig_nxt   = dig_r >> 1;
            carry_nxt = s3[2:1];
          end
          kic_pkg::CMD_ADD, kic_pkg::CMD_SUB: begin
            x_nxt     = {s2[0], x_r[W-1:1]};
            y_nxt     = y_r >> 1;
            carry_nxt = {1'b0, s2[1]};
          end
          kic_pkg::CMD_MUL: begin
            acc_nxt = acc_r + (y_r[0] ? x_r : '0);
            x_nxt   = x_r << 1;
            y_nxt   = y_r >> 1;
          end
          kic_pkg::CMD_DIV: begin
            if (!diff[W]) begin
              rem_nxt = diff[W-1:0];
              x_nxt   = {x_r[W-2:0], 1'b1};
            end else begin
              rem_nxt = rem_sh[W-1:0];
              x_nxt   = {x_r[W-2:0], 1'b0};
            end
          end
          default: begin
          end
        endcase
        if (cnt_r == '0) begin
          st_nxt = E_FIX;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      E_FIX: begin
        if (kind_r == kic_pkg::CMD_MUL) begin
          x_nxt = acc_r;
        end else if (kind_r == kic_pkg::CMD_DIV && neg_r) begin
          x_nxt = W'(0) - x_r;
        end
        done_nxt = 1'b1;
        st_nxt   = E_IDLE;
      end
      default: begin
        st_nxt = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= E_IDLE;
      done_r <= 1'b0;
      err_r  <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
      err_r  <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    cnt_r   <= cnt_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    acc_r   <= acc_nxt;
    rem_r   <= rem_nxt;
    carry_r <= carry_nxt;
    hist_r  <= hist_nxt;
    dig_r   <= dig_nxt;
    neg_r   <= neg_nxt;
  end

  assign sts.done  = done_r;
  assign sts.error = err_r;
  assign result    = x_r;

endmodule

`default_nettype wire

[sv/keypad_integer_calculator.sv]
// Channel  | Ports                         | Direction | Word
// input    | in_valid, in_ready            | in        | in_key_code
// result   | out_valid, out_ready          | out       | out_value, out_error
//
// A digit word occupies the block while the engine builds operand * 10 + digit
// one bit per cycle. An '=' word with an operator runs the engine as well, but
// a division by zero or an '=' with no operator goes straight to the result; the
// word also waits while a full output register waits for out_ready. Other words,
// and a digit word once the key count has reached its limit, leave in_ready high.
// Reset is synchronous and active low and clears operands, operator and count.
`default_nettype none

`include "keypad_integer_calculator_assert.svh"

module keypad_integer_calculator #(
  parameter int unsigned MAX_KEYS   = 16,
  parameter int unsigned DATA_WIDTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_key_code,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_value,
  output logic                    out_error
);

  localparam int unsigned CNT_W = $clog2(MAX_KEYS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ACC  = 2'd1;
  localparam logic [1:0] ST_EVAL = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0]              st_r, st_nxt;
  logic [DATA_WIDTH-1:0]   a_r, a_nxt;
  logic [DATA_WIDTH-1:0]   b_r, b_nxt;
  kic_pkg::op_t            op_r, op_nxt;
  logic                    seen_r, seen_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [15:0]      out_value_r, out_value_nxt;
  logic                    out_error_r, out_error_nxt;

  kic_pkg::eng_cmd_t       eng_cmd;
  kic_pkg::eng_sts_t       eng_sts;
  logic [DATA_WIDTH-1:0]   eng_opa;
  logic [DATA_WIDTH-1:0]   eng_res;
  logic signed [DATA_WIDTH-1:0] res_s;

  logic accept;
  logic is_digit;
  logic is_eq;
  logic full;

  assign in_ready  = (st_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign is_digit  = (in_key_code >= kic_pkg::KEY_0) && (in_key_code <= kic_pkg::KEY_9);
  assign is_eq     = (in_key_code == kic_pkg::KEY_EQ);
  assign full      = (cnt_r >= CNT_W'(MAX_KEYS - 1));
  assign res_s     = eng_res;

  always_comb begin
    eng_cmd.start = accept && (is_eq || (is_digit && !full));
    eng_cmd.kind  = is_eq ? (seen_r ? kic_pkg::op_to_cmd(op_r) : kic_pkg::CMD_PASS)
                          : kic_pkg::CMD_MAC10;
    eng_cmd.digit = 4'(in_key_code - kic_pkg::KEY_0);
    eng_opa       = (!is_eq && seen_r) ? b_r : a_r;
  end

  kic_engine #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (eng_cmd),
    .opa   (eng_opa),
    .opb   (b_r),
    .sts   (eng_sts),
    .result(eng_res)
  );

  always_comb begin
    logic load_out;
    logic clear;
    st_nxt        = st_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    op_nxt        = op_r;
    seen_nxt      = seen_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_error_nxt = out_error_r;
    load_out      = 1'b0;
    clear         = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (st_r)
      ST_IDLE: begin
        if (accept) begin
          priority if (in_key_code == kic_pkg::KEY_NONE) begin
          end else if (is_eq) begin
            st_nxt = ST_EVAL;
          end else if (in_key_code == kic_pkg::KEY_DOT) begin
            clear = 1'b1;
          end else if (full) begin
          end else begin
            cnt_nxt = cnt_r + 1'b1;
            priority if (is_digit) begin
              st_nxt = ST_ACC;
            end else if (in_key_code == kic_pkg::KEY_ADD) begin
              op_nxt   = kic_pkg::OP_ADD;
              seen_nxt = 1'b1;
            end else if (in_key_code == kic_pkg::KEY_SUB) begin
              op_nxt   = kic_pkg::OP_SUB;
              seen_nxt = 1'b1;
            end else if (in_key_code == kic_pkg::KEY_MUL) begin
              op_nxt   = kic_pkg::OP_MUL;
              seen_nxt = 1'b1;
            end else if (in_key_code == kic_pkg::KEY_DIV) begin
              op_nxt   = kic_pkg::OP_DIV;
              seen_nxt = 1'b1;
            end else begin
            end
          end
        end
      end
      ST_ACC: begin
        if (eng_sts.done) begin
          if (seen_r) begin
            b_nxt = eng_res;
          end else begin
            a_nxt = eng_res;
          end
          st_nxt = ST_IDLE;
        end
      end
      ST_EVAL: begin
        if (eng_sts.done) begin
          if (!out_valid_nxt) begin
            load_out = 1'b1;
          end else begin
            st_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (!out_valid_nxt) begin
          load_out = 1'b1;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = 16'(res_s);
      out_error_nxt = eng_sts.error;
      clear         = 1'b1;
      st_nxt        = ST_IDLE;
    end
    if (clear) begin
      a_nxt    = '0;
      b_nxt    = '0;
      op_nxt   = kic_pkg::OP_ADD;
      seen_nxt = 1'b0;
      cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      a_r         <= '0;
      b_r         <= '0;
      op_r        <= kic_pkg::OP_ADD;
      seen_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      a_r         <= a_nxt;
      b_r         <= b_nxt;
      op_r        <= op_nxt;
      seen_r      <= seen_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_error_r <= out_error_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_error = out_error_r;

  `KIC_ASSERT_NOW(a_done_owned, eng_sts.done, st_r == ST_ACC || st_r == ST_EVAL, "stray done")
  `KIC_ASSERT_NOW(a_count_bound, 1'b1, cnt_r <= CNT_W'(MAX_KEYS - 1), "key count overrun")
  `KIC_ASSERT_NEXT(a_eq_evaluates, accept && is_eq, st_r == ST_EVAL, "evaluate key ignored")
  `KIC_ASSERT_NOW(a_error_zero, out_valid_r && out_error_r, ~|out_value_r, "nonzero error word")

endmodule

`default_nettype wire

[test/keypad_integer_calculator_test.sv]
`timescale 1ns / 1ps

module keypad_integer_calculator_test;
  import kic_pkg::*;

  localparam int unsigned MAX_KEYS = 16;
  localparam int unsigned DATA_WIDTH = 16;
  localparam int RANDOM_KEYS = 1250;
  localparam int SETTLE_CYCLES = DATA_WIDTH + 3 + 20;
  localparam int STALL_LIMIT = 4000;
  localparam int SCRIPT_ROWS = 27;
  localparam key_t KEY_OTHER = 8'h41;
  localparam key_t KEY_ALL_ONES = 8'hFF;

  typedef struct packed {
    logic [15:0] value;
    logic        error;
  } calc_result_t;

  typedef struct packed {
    key_t         key;
    logic         typed;
    calc_result_t want;
  } key_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  key_t in_key_code = KEY_NONE;
  logic out_valid;
  logic out_ready = 1'b1;
  logic signed [15:0] out_value;
  logic out_error;

  logic [15:0] lhs_acc;
  logic [15:0] rhs_acc;
  op_t pend_op;
  logic have_op;
  int unsigned keys_held;

  calc_result_t pending_results[$];
  calc_result_t head;
  int mismatches = 0;
  int keys_sent = 0;
  int idle_cycles = 0;
  bit feed_calm = 1'b0;
  bit sink_calm = 1'b0;

  key_t op_keys [4] = '{KEY_ADD, KEY_SUB, KEY_MUL, KEY_DIV};

  key_row_t key_script [SCRIPT_ROWS] = '{
    '{KEY_EQ, 1'b1, '{16'h0000, 1'b0}},
    '{KEY_NONE, 1'b0, '{16'h0000, 1'b0}},
    '{KEY_0 + 8'd7, 1'b0, '{16'h0000, 1'b0}},
    '{KEY_ADD, 1'b0, '{16'h0000, 1'b0}},
    '{KEY_DIV, 1'b0, '{16'h0000, 1'b0}},
    '{KEY_0, 1'b0, '{16'h0000, 1'b0}},
    '{KEY_EQ, 1'b1, '{16'h0000, 1'b1}},
    '{KEY_0 + 8'd3, 1'b0, '{16'h0000, 1'b0}},
    '{KEY_0 + 8'd2, 1'b0, '{16'h0000, 1'b0}},
    '{KEY_0 + 8'd7, 1'b0, '{16'h0000, 1'b0}},
    '{KEY_0 + 8'd6, 1'b0, '{16'h0000, 1'b0}},
    '{KEY_0 + 8'd8, 1'b0, '{16'h0000, 1'b0}},
    '{KEY_DIV, 1'b0, '{16'h0000, 1'b0}},
    '{KEY_0 + 8'd6, 1'b0, '{16'h0000, 1'b0}},
    '{KEY_0 + 8'd5, 1'b0, '{16'h0000, 1'b0}},
    '{KEY_0 + 8'd5, 1'b0, '{16'h0000, 1'b0}},
    '{KEY_0 + 8'd3, 1'b0, '{16'h0000, 1'b0}},
    '{KEY_9 - 8'd4, 1'b0, '{16'h0000, 1'b0}},
    '{KEY_EQ, 1'b1, '{16'h8000, 1'b0}},
    '{KEY_0 + 8'd5, 1'b0, '{16'h0000, 1'b0}},
    '{KEY_SUB, 1'b0, '{16'h0000, 1'b0}},
    '{KEY_9, 1'b0, '{16'h0000, 1'b0}},
    '{KEY_MUL, 1'b0, '{16'h0000, 1'b0}},
    '{KEY_EQ, 1'b0, '{16'h0000, 1'b0}},
    '{KEY_ALL_ONES, 1'b0, '{16'h0000, 1'b0}},
    '{KEY_DOT, 1'b0, '{16'h0000, 1'b0}},
    '{KEY_EQ, 1'b1, '{16'h0000, 1'b0}}
  };

  keypad_integer_calculator #(
    .MAX_KEYS(MAX_KEYS),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_key_code(in_key_code),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_value(out_value),
    .out_error(out_error)
  );

  always #10 clk = ~clk;

  function automatic void clear_calc();
    lhs_acc = '0;
    rhs_acc = '0;
    pend_op = OP_ADD;
    have_op = 1'b0;
    keys_held = 0;
  endfunction

  // Returns 1 when the key produces a result word, which is placed in res.
  function automatic bit take_key(input key_t k, output calc_result_t res);
    logic [15:0] lhs_mag;
    logic [15:0] rhs_mag;
    logic [15:0] quo;
    res.value = '0;
    res.error = 1'b0;
    if (k == KEY_NONE) return 1'b0;
    if (k == KEY_EQ) begin
      if (!have_op) begin
        res.value = lhs_acc;
      end else begin
        case (pend_op)
          OP_ADD: res.value = lhs_acc + rhs_acc;
          OP_SUB: res.value = lhs_acc - rhs_acc;
          OP_MUL: res.value = lhs_acc * rhs_acc;
          default: begin
            if (rhs_acc == '0) begin
              res.error = 1'b1;
            end else begin
              lhs_mag = lhs_acc[15] ? 16'd0 - lhs_acc : lhs_acc;
              rhs_mag = rhs_acc[15] ? 16'd0 - rhs_acc : rhs_acc;
              quo = lhs_mag / rhs_mag;
              res.value = (lhs_acc[15] ^ rhs_acc[15]) ? 16'd0 - quo : quo;
            end
          end
        endcase
      end
      clear_calc();
      return 1'b1;
    end
    if (k == KEY_DOT) begin
      clear_calc();
      return 1'b0;
    end
    if (keys_held >= MAX_KEYS - 1) return 1'b0;
    keys_held++;
    if (k >= KEY_0 && k <= KEY_9) begin
      if (!have_op) lhs_acc = lhs_acc * 16'd10 + 16'(k - KEY_0);
      else rhs_acc = rhs_acc * 16'd10 + 16'(k - KEY_0);
    end else begin
      case (k)
        KEY_ADD: begin pend_op = OP_ADD; have_op = 1'b1; end
        KEY_SUB: begin pend_op = OP_SUB; have_op = 1'b1; end
        KEY_MUL: begin pend_op = OP_MUL; have_op = 1'b1; end
        KEY_DIV: begin pend_op = OP_DIV; have_op = 1'b1; end
        default: ;
      endcase
    end
    return 1'b0;
  endfunction

  function automatic int pick_idle(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  task automatic send_key(input key_row_t row);
    int gap;
    calc_result_t got;
    gap = pick_idle(feed_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_key_code <= row.key;
    do @(posedge clk); while (!in_ready);
    if (take_key(row.key, got)) pending_results.push_back(row.typed ? row.want : got);
    if (row.key != KEY_NONE) keys_sent++;
  endtask

  task automatic send_key_code(input key_t k);
    send_key('{k, 1'b0, calc_result_t'('0)});
  endtask

  task automatic send_digits(input int count);
    repeat (count) begin
      if ($urandom_range(0, 19) == 0) send_key_code(KEY_NONE);
      send_key_code(KEY_0 + key_t'($urandom_range(0, 9)));
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic run_sequence();
    int kind;
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 6) == 0) feed_calm = !feed_calm;
    if (kind < 60) begin
      send_digits($urandom_range(1, 5));
      send_key_code(op_keys[$urandom_range(0, 3)]);
      send_digits($urandom_range(0, 5));
      if ($urandom_range(0, 4) == 0) send_key_code(op_keys[$urandom_range(0, 3)]);
      send_key_code(KEY_EQ);
    end else if (kind < 70) begin
      send_digits($urandom_range(0, 6));
      send_key_code(KEY_EQ);
    end else if (kind < 82) begin
      repeat ($urandom_range(12, 24)) begin
        if ($urandom_range(0, 3) == 0) send_key_code(op_keys[$urandom_range(0, 3)]);
        else send_digits(1);
      end
      send_key_code(KEY_EQ);
    end else if (kind < 94) begin
      repeat ($urandom_range(1, 6)) send_key_code(key_t'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 1) send_key_code(KEY_EQ);
    end else begin
      send_digits($urandom_range(1, 4));
      send_key_code(op_keys[$urandom_range(0, 3)]);
      send_digits($urandom_range(0, 3));
      send_key_code(KEY_DOT);
    end
  endtask

  initial begin : sink_pace
    int stall;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 49) == 0) sink_calm = !sink_calm;
      stall = pick_idle(sink_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("out_value: expected no word, actual %0d", out_value);
        mismatches++;
      end else begin
        head = pending_results.pop_front();
        if (out_value !== head.value) begin
          $error("out_value: expected %0d, actual %0d", $signed(head.value), out_value);
          mismatches++;
        end
        if (out_error !== head.error) begin
          $error("out_error: expected %0d, actual %0d", head.error, out_error);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    int random_base;
    bit paused;
    paused = 1'b0;
    clear_calc();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    foreach (key_script[i]) send_key(key_script[i]);
    drain_results();
    random_base = keys_sent;
    while (keys_sent < random_base + RANDOM_KEYS) begin
      if (!paused && keys_sent > random_base + RANDOM_KEYS / 2) begin
        drain_results();
        paused = 1'b1;
      end
      run_sequence();
    end
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
